### sv/bfx_pkg.sv
// bfx_pkg: shared types, hash constants and the round and finalisation
// microcode for the XXH64 double-hash Bloom filter. No dependencies.
`timescale 1ns / 1ps

package bfx_pkg;

  localparam logic [63:0] SEED_A = 64'h44824EDFA779737D;
  localparam logic [63:0] SEED_B = 64'h90948FBEF5B0B8EB;
  localparam logic [63:0] PR1    = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2    = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3    = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4    = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5    = 64'h27D4EB2F165667C5;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } bfx_in_t;

  typedef struct packed {
    logic done_op;
    logic present;
  } bfx_out_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_ACCEPT, OP_MUL, OP_MOD, OP_ACC_ADDROT, OP_ACC_FROM_T,
    OP_T_ROT, OP_H_ZERO, OP_H_SEED, OP_H_ADD_ROTV, OP_H_ADD_LEN, OP_H_XOR_T,
    OP_H_ROT, OP_H_SET_T, OP_H_SHXOR, OP_PROBE_RD, OP_PROBE_CHK, OP_EMIT
  } dp_op_t;

  // Multiplier operand sources
  typedef enum logic [2:0] {
    SRC_STRIPE, SRC_LANE64, SRC_LANE32, SRC_BYTE, SRC_ACC, SRC_H, SRC_T
  } src_t;

  typedef enum logic [2:0] {K_ZERO, K_PR1, K_PR2, K_PR3, K_PR4, K_PR5} kon_t;

  // Microcode segments
  typedef enum logic [3:0] {
    SEG_ROUND, SEG_BIG, SEG_MERGE, SEG_SMALL, SEG_LEN,
    SEG_TAIL8, SEG_TAIL4, SEG_TAIL1, SEG_AVAL
  } seg_t;

  typedef struct packed {
    dp_op_t      op;
    src_t        src;
    kon_t        kon;
    logic [5:0]  rot;
    logic [3:0]  padv;
    logic [1:0]  ln;
    logic        ln_ctr;
    logic        fin;
  } uinstr_t;

  typedef struct packed {
    dp_op_t      op;
    src_t        src;
    kon_t        kon;
    logic [5:0]  rot;
    logic [3:0]  padv;
    logic [1:0]  lane;
    logic        seed;
    logic        first;
    logic        hit;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic fill_full;
    logic len_ge32;
    logic rem_ge8;
    logic rem_ge4;
    logic rem_gt0;
    logic bit_set;
    logic query;
    logic clr_last;
  } dp_stat_t;

  function automatic logic [63:0] kval(kon_t k);
    logic [63:0] v;
    case (k)
      K_PR1:   v = PR1;
      K_PR2:   v = PR2;
      K_PR3:   v = PR3;
      K_PR4:   v = PR4;
      K_PR5:   v = PR5;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] r);
    return (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  // Initial accumulator lane k for seed select s
  function automatic logic [63:0] seed_lane(logic s, logic [1:0] k);
    logic [63:0] sd;
    logic [63:0] v;
    sd = s ? SEED_B : SEED_A;
    case (k)
      2'd0:    v = sd + PR1 + PR2;
      2'd1:    v = sd + PR2;
      2'd2:    v = sd;
      default: v = sd - PR1;
    endcase
    return v;
  endfunction

  function automatic uinstr_t mk(dp_op_t op, src_t s, kon_t k, logic [5:0] rot,
                                 logic [3:0] padv, logic [1:0] ln, logic lnc,
                                 logic fin);
    uinstr_t u;
    u.op = op; u.src = s; u.kon = k; u.rot = rot; u.padv = padv;
    u.ln = ln; u.ln_ctr = lnc; u.fin = fin;
    return u;
  endfunction

  // Microcode: one instruction per (segment, step)
  function automatic uinstr_t ucode(seg_t seg, logic [2:0] step);
    uinstr_t u;
    u = mk(OP_NOP, SRC_H, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b1);
    case (seg)
      SEG_ROUND: begin
        case (step)
          3'd0: u = mk(OP_MUL, SRC_STRIPE, K_PR2, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd1: u = mk(OP_ACC_ADDROT, SRC_ACC, K_ZERO, 6'd31, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd2: u = mk(OP_MUL, SRC_ACC, K_PR1, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd3: u = mk(OP_ACC_FROM_T, SRC_ACC, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b1, 1'b1);
          default: ;
        endcase
      end
      SEG_BIG: begin
        case (step)
          3'd0: u = mk(OP_H_ZERO, SRC_H, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd1: u = mk(OP_H_ADD_ROTV, SRC_ACC, K_ZERO, 6'd1, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd2: u = mk(OP_H_ADD_ROTV, SRC_ACC, K_ZERO, 6'd7, 4'd0, 2'd1, 1'b0, 1'b0);
          3'd3: u = mk(OP_H_ADD_ROTV, SRC_ACC, K_ZERO, 6'd12, 4'd0, 2'd2, 1'b0, 1'b0);
          3'd4: u = mk(OP_H_ADD_ROTV, SRC_ACC, K_ZERO, 6'd18, 4'd0, 2'd3, 1'b0, 1'b1);
          default: ;
        endcase
      end
      SEG_MERGE: begin
        case (step)
          3'd0: u = mk(OP_MUL, SRC_ACC, K_PR2, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd1: u = mk(OP_T_ROT, SRC_T, K_ZERO, 6'd31, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd2: u = mk(OP_MUL, SRC_T, K_PR1, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd3: u = mk(OP_H_XOR_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd4: u = mk(OP_MUL, SRC_H, K_PR1, 6'd0, 4'd0, 2'd0, 1'b1, 1'b0);
          3'd5: u = mk(OP_H_SET_T, SRC_T, K_PR4, 6'd0, 4'd0, 2'd0, 1'b1, 1'b1);
          default: ;
        endcase
      end
      SEG_SMALL: u = mk(OP_H_SEED, SRC_H, K_PR5, 6'd0, 4'd0, 2'd0, 1'b0, 1'b1);
      SEG_LEN:   u = mk(OP_H_ADD_LEN, SRC_H, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b1);
      SEG_TAIL8: begin
        case (step)
          3'd0: u = mk(OP_MUL, SRC_LANE64, K_PR2, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd1: u = mk(OP_T_ROT, SRC_T, K_ZERO, 6'd31, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd2: u = mk(OP_MUL, SRC_T, K_PR1, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd3: u = mk(OP_H_XOR_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd4: u = mk(OP_H_ROT, SRC_H, K_ZERO, 6'd27, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd5: u = mk(OP_MUL, SRC_H, K_PR1, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd6: u = mk(OP_H_SET_T, SRC_T, K_PR4, 6'd0, 4'd8, 2'd0, 1'b0, 1'b1);
          default: ;
        endcase
      end
      SEG_TAIL4: begin
        case (step)
          3'd0: u = mk(OP_MUL, SRC_LANE32, K_PR1, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd1: u = mk(OP_H_XOR_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd2: u = mk(OP_H_ROT, SRC_H, K_ZERO, 6'd23, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd3: u = mk(OP_MUL, SRC_H, K_PR2, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd4: u = mk(OP_H_SET_T, SRC_T, K_PR3, 6'd0, 4'd4, 2'd0, 1'b0, 1'b1);
          default: ;
        endcase
      end
      SEG_TAIL1: begin
        case (step)
          3'd0: u = mk(OP_MUL, SRC_BYTE, K_PR5, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd1: u = mk(OP_H_XOR_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd2: u = mk(OP_H_ROT, SRC_H, K_ZERO, 6'd11, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd3: u = mk(OP_MUL, SRC_H, K_PR1, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd4: u = mk(OP_H_SET_T, SRC_T, K_ZERO, 6'd0, 4'd1, 2'd0, 1'b0, 1'b1);
          default: ;
        endcase
      end
      SEG_AVAL: begin
        case (step)
          3'd0: u = mk(OP_H_SHXOR, SRC_H, K_ZERO, 6'd33, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd1: u = mk(OP_MUL, SRC_H, K_PR2, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd2: u = mk(OP_H_SET_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd3: u = mk(OP_H_SHXOR, SRC_H, K_ZERO, 6'd29, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd4: u = mk(OP_MUL, SRC_H, K_PR3, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd5: u = mk(OP_H_SET_T, SRC_T, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd6: u = mk(OP_H_SHXOR, SRC_H, K_ZERO, 6'd32, 4'd0, 2'd0, 1'b0, 1'b0);
          3'd7: u = mk(OP_MOD, SRC_H, K_ZERO, 6'd0, 4'd0, 2'd0, 1'b0, 1'b1);
          default: ;
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

### sv/bfx_ram.sv
// bfx_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bfx_dp.sv
// bfx_dp: hashing datapath (stripe buffer, XXH64 lanes, shared 32x32 multiplier,
// reciprocal modulo unit) and filter probe logic. Depends on bfx_pkg.
`timescale 1ns / 1ps

module bfx_dp import bfx_pkg::*; #(
  parameter longint FILTER_BITS = 1048576,
  localparam int RB    = $clog2(FILTER_BITS),
  localparam int WORDS = int'((FILTER_BITS + 63) / 64),
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  bfx_in_t       req,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [63:0]   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [63:0]   ram_rdata,
  output logic          result_valid,
  output bfx_out_t      result
);

  localparam logic [RB:0] NMOD = (RB + 1)'(FILTER_BITS);
  localparam int IW = (RB > AW + 6) ? RB : AW + 6;
  // folded sum width and quotient estimate width
  localparam int SW = RB + 11;
  localparam int QW = 12;

  // byte weights: 2^(8j) mod FILTER_BITS, j = 0..7
  function automatic logic [8*RB-1:0] wtab_init();
    logic [8*RB-1:0] v;
    longint unsigned w;
    v = '0;
    w = 1;
    for (int j = 0; j < 8; j++) begin
      v[j*RB +: RB] = RB'(w);
      w = (w * 256) % FILTER_BITS;
    end
    return v;
  endfunction

  localparam logic [8*RB-1:0] WTAB = wtab_init();
  // reciprocal: floor(2^SW / FILTER_BITS), below 2^12
  localparam logic [QW-1:0] MREC = QW'((longint'(1) << SW) / FILTER_BITS);

  logic [255:0]  stripe;
  logic [4:0]    fill;
  logic [4:0]    p;
  logic [63:0]   len;
  logic [63:0]   acc [8];
  logic [63:0]   h;
  logic [63:0]   t;
  logic          pending_op;
  logic [AW-1:0] clr_addr;

  // multiplier state
  logic [63:0]   ma, mb, macc, prod;
  logic          mul_run;
  logic [1:0]    mul_ph;

  // modulo unit state
  logic [63:0]   mdiv;
  logic [SW-1:0] msum, mr;
  logic [QW-1:0] mq;
  logic [RB-1:0] idx, stride;
  logic [5:0]    mcnt;
  logic          mod_run;
  logic          mseed;

  logic [2:0]    jsel;
  logic [63:0]   acc_cur;
  logic [4:0]    off;
  logic [63:0]   lane64;
  logic [63:0]   opa;
  logic [31:0]   mx_a, mx_b;
  logic [2:0]       mj;
  logic [7:0]       mbyte;
  logic [RB-1:0]    wsel;
  logic [RB+7:0]    bterm;
  logic [SW+QW-1:0] sq;
  logic [QW+RB:0]   qn;
  logic [SW-1:0]    mfin;
  logic [RB-1:0]    mres;
  logic [RB:0]   psum;
  logic [RB-1:0] idx_n;
  logic [IW-1:0] idx_w;
  logic [AW-1:0] word_addr;
  logic [4:0]    tail_left;

  // operand selection
  assign jsel    = {cmd.seed, cmd.lane};
  assign acc_cur = acc[jsel];
  assign off     = (cmd.src == SRC_STRIPE) ? {cmd.lane, 3'b000} : p;
  assign lane64  = 64'(stripe >> {off, 3'b000});

  always_comb begin
    case (cmd.src)
      SRC_STRIPE, SRC_LANE64: opa = lane64;
      SRC_LANE32:             opa = {32'd0, lane64[31:0]};
      SRC_BYTE:               opa = {56'd0, lane64[7:0]};
      SRC_ACC:                opa = acc_cur;
      SRC_H:                  opa = h;
      default:                opa = t;
    endcase
  end

  // partial-product selection for the shared multiplier
  assign mx_a = (mul_ph == 2'd2) ? ma[63:32] : ma[31:0];
  assign mx_b = (mul_ph == 2'd1) ? mb[63:32] : mb[31:0];

  // remainder terms: weighted byte, quotient estimate, its multiple, one correction
  assign mj    = 3'(mcnt - 6'd3);
  assign mbyte = mdiv[{mj, 3'b000} +: 8];
  assign wsel  = WTAB[int'(mj) * RB +: RB];
  assign bterm = {8'd0, wsel} * {{RB{1'b0}}, mbyte};
  assign sq    = {{QW{1'b0}}, msum} * {{SW{1'b0}}, MREC};
  assign qn    = {{(RB+1){1'b0}}, mq} * {{QW{1'b0}}, NMOD};
  assign mfin  = (mr >= SW'(NMOD)) ? mr - SW'(NMOD) : mr;
  assign mres  = RB'(mfin);

  // probe index step
  assign psum  = {1'b0, idx} + {1'b0, stride};
  assign idx_n = (psum >= NMOD) ? RB'(psum - NMOD) : RB'(psum);

  assign idx_w     = IW'(idx);
  assign word_addr = AW'(idx_w >> 6);
  assign tail_left = fill - p;

  // filter memory access
  assign ram_re    = (cmd.op == OP_PROBE_RD);
  assign ram_raddr = word_addr;
  assign ram_we    = (cmd.op == OP_CLR) || (cmd.op == OP_PROBE_CHK && !pending_op);
  assign ram_waddr = (cmd.op == OP_CLR) ? clr_addr : word_addr;
  assign ram_wdata = (cmd.op == OP_CLR) ? 64'd0 : (ram_rdata | (64'd1 << idx[5:0]));

  // status to controller
  assign stat.unit_done = (mul_run && mul_ph == 2'd3) || (mod_run && mcnt == 6'd0);
  assign stat.fill_full = (fill == 5'd31);
  assign stat.len_ge32  = |len[63:5];
  assign stat.rem_ge8   = (tail_left >= 5'd8);
  assign stat.rem_ge4   = (tail_left >= 5'd4);
  assign stat.rem_gt0   = (tail_left != 5'd0);
  assign stat.bit_set   = ram_rdata[idx[5:0]];
  assign stat.query     = pending_op;
  assign stat.clr_last  = (clr_addr == AW'(WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) begin
        acc[j] <= seed_lane(1'(j >> 2), 2'(j));
      end
      fill         <= 5'd0;
      p            <= 5'd0;
      len          <= 64'd0;
      pending_op   <= 1'b0;
      clr_addr     <= '0;
      mul_run      <= 1'b0;
      mul_ph       <= 2'd0;
      mod_run      <= 1'b0;
      mcnt         <= 6'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      // shared multiplier: four partial-product phases, low 64 bits kept
      if (mul_run) begin
        prod   <= 64'(mx_a * mx_b);
        mul_ph <= mul_ph + 2'd1;
        case (mul_ph)
          2'd1:    macc <= prod;
          2'd2:    macc <= macc + {prod[31:0], 32'd0};
          2'd3: begin
            t       <= macc + {prod[31:0], 32'd0};
            mul_run <= 1'b0;
          end
          default: ;
        endcase
      end

      // remainder: 8 byte folds, quotient estimate, multiple, correction
      if (mod_run) begin
        mcnt <= mcnt - 6'd1;
        if (mcnt >= 6'd3) begin
          msum <= msum + SW'(bterm);
        end else if (mcnt == 6'd2) begin
          mq <= sq[SW +: QW];
        end else if (mcnt == 6'd1) begin
          mr <= msum - qn[SW-1:0];
        end else begin
          mod_run <= 1'b0;
          if (mseed) begin
            stride <= mres;
          end else begin
            idx <= mres;
          end
        end
      end

      case (cmd.op)
        OP_CLR: clr_addr <= clr_addr + AW'(1);
        OP_ACCEPT: begin
          if (cmd.first) begin
            pending_op <= req.op;
          end
          if (req.byte_valid) begin
            stripe[{fill, 3'b000} +: 8] <= req.data_byte;
            fill <= fill + 5'd1;
            len  <= len + 64'd1;
          end
        end
        OP_MUL: begin
          ma      <= opa;
          mb      <= kval(cmd.kon);
          mul_run <= 1'b1;
          mul_ph  <= 2'd0;
        end
        OP_MOD: begin
          mdiv    <= h;
          msum    <= '0;
          mcnt    <= 6'd10;
          mseed   <= cmd.seed;
          mod_run <= 1'b1;
        end
        OP_ACC_ADDROT: acc[jsel] <= rotl64(acc_cur + t, cmd.rot);
        OP_ACC_FROM_T: acc[jsel] <= t;
        OP_T_ROT:      t <= rotl64(t, cmd.rot);
        OP_H_ZERO: begin
          h <= 64'd0;
          p <= 5'd0;
        end
        OP_H_SEED: begin
          h <= (cmd.seed ? SEED_B : SEED_A) + kval(cmd.kon);
          p <= 5'd0;
        end
        OP_H_ADD_ROTV: h <= h + rotl64(acc_cur, cmd.rot);
        OP_H_ADD_LEN:  h <= h + len;
        OP_H_XOR_T:    h <= h ^ t;
        OP_H_ROT:      h <= rotl64(h, cmd.rot);
        OP_H_SET_T: begin
          h <= t + kval(cmd.kon);
          p <= p + 5'(cmd.padv);
        end
        OP_H_SHXOR:    h <= h ^ (h >> cmd.rot);
        OP_PROBE_CHK:  idx <= idx_n;
        OP_EMIT: begin
          result_valid   <= 1'b1;
          result.done_op <= pending_op;
          result.present <= cmd.hit;
          for (int j = 0; j < 8; j++) begin
            acc[j] <= seed_lane(1'(j >> 2), 2'(j));
          end
          fill <= 5'd0;
          len  <= 64'd0;
          p    <= 5'd0;
        end
        default: ;
      endcase
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(mul_run && mod_run))
    else $error("multiplier and modulo unit busy together");
  a_tail_ptr: assert property (@(posedge clk) disable iff (rst) p <= fill)
    else $error("tail pointer beyond buffered bytes");
  a_pulse: assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

endmodule

### sv/bfx_ctrl.sv
// bfx_ctrl: controller state machine; sequences byte intake, stripe rounds,
// finalisation microcode, modulo, probes and the result. Depends on bfx_pkg.
`timescale 1ns / 1ps

module bfx_ctrl import bfx_pkg::*; #(
  parameter int PROBE_COUNT = 7,
  localparam int PW = $clog2(PROBE_COUNT + 1)
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  bfx_in_t  req,
  output logic     busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RUN, S_FIN, S_TAIL, S_PROBE_RD, S_PROBE_CHK, S_EMIT
  } state_t;

  state_t        state;
  seg_t          seg;
  logic [2:0]    step;
  logic [2:0]    cnt;
  logic          seed;
  logic          waiting;
  logic          last_pend;
  logic          elem_open;
  logic          hit;
  logic [PW-1:0] pcnt;

  uinstr_t cur;
  logic    is_long;
  logic    adv;

  assign cur     = ucode(seg, step);
  assign is_long = (cur.op == OP_MUL) || (cur.op == OP_MOD);
  assign adv     = is_long ? (waiting && stat.unit_done) : 1'b1;
  assign busy    = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NOP;
    cmd.src   = cur.src;
    cmd.kon   = cur.kon;
    cmd.rot   = cur.rot;
    cmd.padv  = cur.padv;
    cmd.seed  = (seg == SEG_ROUND) ? cnt[2] : seed;
    cmd.lane  = (seg == SEG_ROUND || cur.ln_ctr) ? cnt[1:0] : cur.ln;
    cmd.first = !elem_open;
    cmd.hit   = hit;
    unique case (state)
      S_CLEAR:     cmd.op = OP_CLR;
      S_IDLE:      cmd.op = start ? OP_ACCEPT : OP_NOP;
      S_RUN:       cmd.op = waiting ? OP_NOP : cur.op;
      S_PROBE_RD:  cmd.op = OP_PROBE_RD;
      S_PROBE_CHK: cmd.op = OP_PROBE_CHK;
      S_EMIT:      cmd.op = OP_EMIT;
      default:     cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      seg       <= SEG_ROUND;
      step      <= 3'd0;
      cnt       <= 3'd0;
      seed      <= 1'b0;
      waiting   <= 1'b0;
      last_pend <= 1'b0;
      elem_open <= 1'b0;
      hit       <= 1'b0;
      pcnt      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            elem_open <= 1'b1;
            seed      <= 1'b0;
            last_pend <= req.last;
            if (req.byte_valid && stat.fill_full) begin
              state <= S_RUN;
              seg   <= SEG_ROUND;
              step  <= 3'd0;
              cnt   <= 3'd0;
            end else if (req.last) begin
              state <= S_FIN;
            end
          end
        end
        S_RUN: begin
          if (is_long && !waiting) begin
            waiting <= 1'b1;
          end else if (adv) begin
            waiting <= 1'b0;
            step    <= step + 3'd1;
            if (cur.fin) begin
              step <= 3'd0;
              case (seg)
                SEG_ROUND: begin
                  cnt <= cnt + 3'd1;
                  if (cnt == 3'd7) begin
                    state <= last_pend ? S_FIN : S_IDLE;
                  end
                end
                SEG_BIG: begin
                  seg <= SEG_MERGE;
                  cnt <= 3'd0;
                end
                SEG_MERGE: begin
                  cnt <= cnt + 3'd1;
                  if (cnt == 3'd3) begin
                    seg <= SEG_LEN;
                  end
                end
                SEG_SMALL: seg <= SEG_LEN;
                SEG_AVAL: begin
                  if (!seed) begin
                    seed  <= 1'b1;
                    state <= S_FIN;
                  end else begin
                    pcnt  <= '0;
                    state <= S_PROBE_RD;
                  end
                end
                default: state <= S_TAIL;
              endcase
            end
          end
        end
        // choose head form for this seed
        S_FIN: begin
          seg   <= stat.len_ge32 ? SEG_BIG : SEG_SMALL;
          step  <= 3'd0;
          state <= S_RUN;
        end
        // choose next tail segment from bytes still unconsumed
        S_TAIL: begin
          if (stat.rem_ge8) begin
            seg <= SEG_TAIL8;
          end else if (stat.rem_ge4) begin
            seg <= SEG_TAIL4;
          end else if (stat.rem_gt0) begin
            seg <= SEG_TAIL1;
          end else begin
            seg <= SEG_AVAL;
          end
          step  <= 3'd0;
          state <= S_RUN;
        end
        S_PROBE_RD: state <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (stat.query && !stat.bit_set) begin
            hit   <= 1'b0;
            state <= S_EMIT;
          end else if (pcnt == PW'(PROBE_COUNT - 1)) begin
            hit   <= stat.query;
            state <= S_EMIT;
          end else begin
            pcnt  <= pcnt + PW'(1);
            state <= S_PROBE_RD;
          end
        end
        S_EMIT: begin
          elem_open <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_wait_run: assert property (@(posedge clk) disable iff (rst)
    waiting |-> (state == S_RUN && is_long))
    else $error("waiting outside a multi-cycle step");
  a_chk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CHK) |-> ($past(state) == S_PROBE_RD))
    else $error("probe check without preceding read");

endmodule

### sv/bloom_filter_xxh64_double_hash.sv
// bloom_filter_xxh64_double_hash: top level; joins controller, datapath and filter RAM.
// Depends on bfx_pkg, bfx_ram, bfx_dp, bfx_ctrl.
//
//   channel   ports                    handshake
//   input     req (bfx_in_t)           start high, busy low
//   result    result (bfx_out_t)       result_valid, one cycle, no stall
//
// A byte that neither completes a stripe nor ends the item leaves busy low,
// ready for the next byte. Every 32nd byte adds 8 lane rounds, each with two
// 64-bit products on the single shared 32x32 multiplier. The last item adds
// finalisation for both seeds (its steps set by element length and tail bytes,
// ending in the modulo remainder), then one read and one check per probe
// through the filter RAM read port, then the result. After reset the filter RAM
// is swept clear with busy high. Results cannot be held off.
`timescale 1ns / 1ps

module bloom_filter_xxh64_double_hash import bfx_pkg::*; #(
  parameter longint FILTER_BITS = 1048576,
  parameter int     PROBE_COUNT = 7
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  bfx_in_t  req,
  output logic     result_valid,
  output bfx_out_t result
);

  localparam int WORDS = int'((FILTER_BITS + 63) / 64);
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  bfx_ctrl #(.PROBE_COUNT(PROBE_COUNT)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  bfx_dp #(.FILTER_BITS(FILTER_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .stat         (stat),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  bfx_ram #(.WIDTH(64), .DEPTH(WORDS)) u_filter (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
